[src/assert_macros.svh]
// assertion macros used by k_weighted_block_mean_square
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define KW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define KW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/kwbms_pkg.sv]
// types and constants of the k-weighted block mean square unit
package kwbms_pkg;

    localparam int unsigned NUM_CH   = 6;
    localparam int unsigned REG_W    = 63;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned Y_W      = 28;
    localparam int unsigned X_W      = 24;
    localparam int unsigned SUM_W    = 56;
    localparam int unsigned FRAME_W  = 36;
    localparam int unsigned OUT_W    = 40;
    localparam int unsigned W_W      = 17;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SHELF_FF  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SHELF_FB  = 3'd1;
    localparam logic [IDX_W-1:0] REG_HP_FF     = 3'd2;
    localparam logic [IDX_W-1:0] REG_HP_FB     = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLOCK_LEN = 3'd4;
    localparam logic [IDX_W-1:0] REG_ACTIVE_CH = 3'd5;

    localparam logic [15:0] BLOCK_LEN_RST = 16'd4800;
    localparam logic [2:0]  ACTIVE_CH_RST = 3'd2;

    localparam logic signed [Y_W-1:0] Y_MAX = 28'sh7ffffff;
    localparam logic signed [Y_W-1:0] Y_MIN = -28'sh8000000;

    // channel weights, q.16
    localparam logic [W_W-1:0] CH_WEIGHT [NUM_CH] = '{
        17'd65536, 17'd65536, 17'd65536, 17'd0, 17'd92682, 17'd92682
    };

    // per-channel filter history; high-pass input history equals shelf output history
    typedef struct packed {
        logic signed [X_W-1:0] sx1;
        logic signed [X_W-1:0] sx2;
        logic signed [Y_W-1:0] sy1;
        logic signed [Y_W-1:0] sy2;
        logic signed [Y_W-1:0] hy1;
        logic signed [Y_W-1:0] hy2;
    } t_hist;

endpackage

[src/k_weighted_block_mean_square.sv]
// k-weighted block mean square: two biquads per channel, weighted squares, block mean
//
//  channel | signals                                   | word
//  --------+-------------------------------------------+------------------------------
//  input   | i_in_valid / o_in_ready                   | six channel samples
//  output  | o_out_valid / i_out_ready                 | o_mean_square, once per block
//  config  | i_cfg_we, i_cfg_index, i_cfg_data         | one register write, no wait
//
//  for each active channel of a word, one shared 32x28 multiplier runs
//  five products per biquad and the square, and the history memory is read and
//  written back once per channel
//  the last word of a block also runs the bit-serial mean divider
//  reset clears the history valid bits, so no clearing pass is needed
//  a finished mean waits in the output register while the next word is taken
//  the end of a block stalls only if the previous mean has not been taken yet
`include "assert_macros.svh"

module k_weighted_block_mean_square #(
    parameter int MAX_CHANNELS = 6,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]     i_right_sample,
    input  logic signed [SAMPLE_BITS-1:0]     i_centre_sample,
    input  logic signed [SAMPLE_BITS-1:0]     i_lfe_sample,
    input  logic signed [SAMPLE_BITS-1:0]     i_left_surround_sample,
    input  logic signed [SAMPLE_BITS-1:0]     i_right_surround_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [kwbms_pkg::OUT_W-1:0]       o_mean_square,
    input  logic                              i_cfg_we,
    input  logic [kwbms_pkg::IDX_W-1:0]       i_cfg_index,
    input  logic [kwbms_pkg::REG_W-1:0]       i_cfg_data
);
    import kwbms_pkg::*;

    localparam int unsigned CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned SH_L = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
    localparam int unsigned SH_R = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
    localparam int unsigned HIST_W = $bits(t_hist);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_MAC  = 4'd2;
    localparam logic [3:0] S_RND  = 4'd3;
    localparam logic [3:0] S_SQ   = 4'd4;
    localparam logic [3:0] S_TW   = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    // configuration
    logic [REG_W-1:0] r_shelf_ff;
    logic [REG_W-1:0] r_shelf_fb;
    logic [REG_W-1:0] r_hp_ff;
    logic [REG_W-1:0] r_hp_fb;
    logic [15:0]      r_block_len;
    logic [2:0]       r_active_ch;

    // control
    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic [2:0]         r_ch;
    logic [2:0]         r_step;
    logic               r_stage;
    logic [15:0]        r_cnt;
    logic [5:0]         r_dcnt;
    logic [MAX_CHANNELS-1:0] r_vld;
    logic               r_ovld;

    // datapath
    logic signed [X_W-1:0]   r_x [NUM_CH];
    logic [HIST_W-1:0]       mem [MAX_CHANNELS];
    logic [HIST_W-1:0]       r_rd_data;
    logic                    r_rd_vld;
    logic signed [63:0]      r_prod;
    logic signed [63:0]      r_acc;
    logic signed [Y_W-1:0]   r_ys;
    logic signed [Y_W-1:0]   r_yh;
    logic [58:0]             r_tw;
    logic [FRAME_W-1:0]      r_frame;
    logic [SUM_W-1:0]        r_sum;
    logic [15:0]             r_dlen;
    logic [16:0]             r_rem;
    logic [56:0]             r_quo;
    logic [OUT_W-1:0]        r_mean;

    logic signed [SAMPLE_BITS-1:0] c_in [NUM_CH];
    logic signed [X_W-1:0]   c_x24 [NUM_CH];
    logic [2:0]              c_nch;
    logic [15:0]             c_len;
    logic [CH_W-1:0]         c_idx;
    t_hist                   c_hist;
    t_hist                   c_new;
    logic signed [31:0]      c_ma;
    logic signed [Y_W-1:0]   c_mb;
    logic signed [59:0]      c_mp;
    logic signed [63:0]      c_pext;
    logic signed [63:0]      c_rnd;
    logic signed [Y_W-1:0]   c_y;
    logic [55:0]             c_sq;
    logic [41:0]             c_t;
    logic [59:0]             c_wsum;
    logic [FRAME_W-1:0]      c_weighted;
    logic [SUM_W:0]          c_bsum;
    logic [SUM_W-1:0]        c_bsat;
    logic [16:0]             c_rsh;
    logic                    c_ge;
    logic                    c_last_ch;
    logic                    c_out_free;

    assign c_in[0] = i_left_sample;
    assign c_in[1] = i_right_sample;
    assign c_in[2] = i_centre_sample;
    assign c_in[3] = i_lfe_sample;
    assign c_in[4] = i_left_surround_sample;
    assign c_in[5] = i_right_surround_sample;

    // bring samples to q1.23, floor when narrowing
    always_comb begin
        logic signed [55:0] ext;
        for (int k = 0; k < NUM_CH; k++) begin
            ext = 56'(c_in[k]);
            ext = (ext <<< SH_L) >>> SH_R;
            c_x24[k] = ext[X_W-1:0];
        end
    end

    always_comb begin
        if (r_active_ch == 3'd0) begin
            c_nch = 3'd1;
        end else if (r_active_ch > 3'd6) begin
            c_nch = 3'd6;
        end else begin
            c_nch = r_active_ch;
        end
        if (c_nch > 3'(MAX_CHANNELS)) begin
            c_nch = 3'(MAX_CHANNELS);
        end
    end

    assign c_len      = (r_block_len == 16'd0) ? 16'd1 : r_block_len;
    assign c_idx      = r_ch[CH_W-1:0];
    assign c_hist     = r_rd_vld ? t_hist'(r_rd_data) : t_hist'('0);
    assign c_last_ch  = (r_ch + 3'd1) >= c_nch;
    assign c_out_free = !r_ovld || i_out_ready;

    // shared multiplier operand select
    always_comb begin
        logic [REG_W-1:0] ff;
        logic [REG_W-1:0] fb;
        logic signed [Y_W-1:0] xin;
        logic signed [Y_W-1:0] x1;
        logic signed [Y_W-1:0] x2;
        logic signed [Y_W-1:0] y1;
        logic signed [Y_W-1:0] y2;
        ff  = r_stage ? r_hp_ff : r_shelf_ff;
        fb  = r_stage ? r_hp_fb : r_shelf_fb;
        xin = r_stage ? r_ys : Y_W'(r_x[r_ch]);
        x1  = r_stage ? c_hist.sy1 : Y_W'(c_hist.sx1);
        x2  = r_stage ? c_hist.sy2 : Y_W'(c_hist.sx2);
        y1  = r_stage ? c_hist.hy1 : c_hist.sy1;
        y2  = r_stage ? c_hist.hy2 : c_hist.sy2;
        c_ma = '0;
        c_mb = '0;
        if (r_state == S_SQ) begin
            c_ma = 32'(r_yh);
            c_mb = r_yh;
        end else begin
            case (r_step)
                3'd0: begin
                    c_ma = 32'(signed'(ff[20:0]));
                    c_mb = xin;
                end
                3'd1: begin
                    c_ma = 32'(signed'(ff[41:21]));
                    c_mb = x1;
                end
                3'd2: begin
                    c_ma = 32'(signed'(ff[62:42]));
                    c_mb = x2;
                end
                3'd3: begin
                    c_ma = signed'(fb[31:0]);
                    c_mb = y1;
                end
                3'd4: begin
                    c_ma = 32'(signed'(fb[62:32]));
                    c_mb = y2;
                end
                default: begin
                    c_ma = '0;
                    c_mb = '0;
                end
            endcase
        end
    end

    assign c_mp   = c_ma * c_mb;
    assign c_pext = 64'(c_mp);

    // round half up to q.23 and saturate
    assign c_rnd = (r_acc + 64'sd536870912) >>> 30;
    always_comb begin
        if (c_rnd > 64'(Y_MAX)) begin
            c_y = Y_MAX;
        end else if (c_rnd < 64'(Y_MIN)) begin
            c_y = Y_MIN;
        end else begin
            c_y = c_rnd[Y_W-1:0];
        end
    end

    assign c_sq       = r_prod[55:0] + 56'd8192;
    assign c_t        = c_sq[55:14];
    assign c_wsum     = {1'b0, r_tw} + 60'd8388608;
    assign c_weighted = c_wsum[59:24];
    assign c_bsum     = {1'b0, r_sum} + (SUM_W+1)'(r_frame);
    assign c_bsat     = c_bsum[SUM_W] ? {SUM_W{1'b1}} : c_bsum[SUM_W-1:0];
    assign c_rsh      = {r_rem[15:0], r_quo[56]};
    assign c_ge       = c_rsh >= {1'b0, r_dlen};

    assign c_new.sx1 = r_x[r_ch];
    assign c_new.sx2 = c_hist.sx1;
    assign c_new.sy1 = r_ys;
    assign c_new.sy2 = c_hist.sy1;
    assign c_new.hy1 = r_yh;
    assign c_new.hy2 = c_hist.hy1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_READ;
            S_READ: n_state = S_MAC;
            S_MAC:  if (r_step == 3'd5) n_state = S_RND;
            S_RND:  n_state = r_stage ? S_SQ : S_MAC;
            S_SQ:   n_state = S_TW;
            S_TW:   n_state = S_ACC;
            S_ACC:  n_state = c_last_ch ? S_SUM : S_READ;
            S_SUM:  n_state = ((17'(r_cnt) + 17'd1) >= 17'(c_len)) ? S_DIV : S_IDLE;
            S_DIV:  if (r_dcnt == 6'd0) n_state = S_OUT;
            S_OUT:  if (c_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shelf_ff  <= '0;
            r_shelf_fb  <= '0;
            r_hp_ff     <= '0;
            r_hp_fb     <= '0;
            r_block_len <= BLOCK_LEN_RST;
            r_active_ch <= ACTIVE_CH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SHELF_FF:  r_shelf_ff  <= i_cfg_data;
                REG_SHELF_FB:  r_shelf_fb  <= i_cfg_data;
                REG_HP_FF:     r_hp_ff     <= i_cfg_data;
                REG_HP_FB:     r_hp_fb     <= i_cfg_data;
                REG_BLOCK_LEN: r_block_len <= i_cfg_data[15:0];
                REG_ACTIVE_CH: r_active_ch <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_ACC) begin
            mem[c_idx] <= c_new;
        end
        if (r_state == S_READ) begin
            r_rd_data <= mem[c_idx];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch     <= '0;
            r_step   <= '0;
            r_stage  <= 1'b0;
            r_cnt    <= '0;
            r_dcnt   <= '0;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_sum    <= '0;
            r_ovld   <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_ch <= '0;
                end
                S_READ: begin
                    r_rd_vld <= r_vld[c_idx];
                    r_step   <= '0;
                    r_stage  <= 1'b0;
                end
                S_MAC: begin
                    r_step <= r_step + 3'd1;
                end
                S_RND: begin
                    r_step  <= '0;
                    r_stage <= 1'b1;
                end
                S_ACC: begin
                    r_vld[c_idx] <= 1'b1;
                    r_ch         <= r_ch + 3'd1;
                end
                S_SUM: begin
                    if ((17'(r_cnt) + 17'd1) >= 17'(c_len)) begin
                        r_sum  <= '0;
                        r_cnt  <= '0;
                        r_dcnt <= 6'd56;
                    end else begin
                        r_sum <= c_bsat;
                        r_cnt <= r_cnt + 16'd1;
                    end
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt - 6'd1;
                end
                default: ;
            endcase
            if (r_state == S_OUT && c_out_free) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    for (int k = 0; k < NUM_CH; k++) begin
                        r_x[k] <= c_x24[k];
                    end
                end
                r_frame <= '0;
            end
            S_MAC: begin
                if (r_step <= 3'd2) begin
                    r_prod <= c_pext <<< 12;
                end else begin
                    r_prod <= c_pext;
                end
                if (r_step == 3'd1) begin
                    r_acc <= r_prod;
                end else if (r_step >= 3'd2) begin
                    r_acc <= r_acc + r_prod;
                end
            end
            S_RND: begin
                if (r_stage) begin
                    r_yh <= c_y;
                end else begin
                    r_ys <= c_y;
                end
            end
            S_SQ: begin
                r_prod <= c_pext;
            end
            S_TW: begin
                r_tw <= 59'(c_t * CH_WEIGHT[r_ch]);
            end
            S_ACC: begin
                r_frame <= r_frame + c_weighted;
            end
            S_SUM: begin
                r_dlen <= c_len;
                r_rem  <= '0;
                r_quo  <= {1'b0, c_bsat} + 57'(c_len >> 1);
            end
            S_DIV: begin
                r_rem <= c_ge ? (c_rsh - {1'b0, r_dlen}) : c_rsh;
                r_quo <= {r_quo[55:0], c_ge};
            end
            S_OUT: begin
                if (c_out_free) begin
                    r_mean <= (r_quo[56:OUT_W] != '0) ? {OUT_W{1'b1}} : r_quo[OUT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_ovld;
    assign o_mean_square = r_mean;

    `KW_ASSERT_NEXT(a_accept_starts_read, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_READ && r_ch == 3'd0, "accepted word did not start at channel zero")
    `KW_ASSERT_IMPLY(a_channel_in_range, i_clk, i_rst_n, r_state == S_ACC, r_ch < c_nch, "history write beyond active channels")
    `KW_ASSERT_NEXT(a_mean_loaded, i_clk, i_rst_n, r_state == S_OUT && c_out_free, o_out_valid && r_state == S_IDLE, "finished mean not presented")
    `KW_ASSERT_IMPLY(a_div_remainder, i_clk, i_rst_n, r_state == S_DIV, r_rem < {1'b0, r_dlen}, "divider remainder out of range")

endmodule
